>>> src/m3i_pkg.sv
// shared types and constants for the 3x3 matrix inverse pipeline
package m3i_pkg;

   localparam int DATA_W       = 32;
   localparam int N_ELEM       = 9;
   localparam int N_ROW        = 3;
   localparam int PROD_W       = 2 * DATA_W;
   localparam int ADJ_W        = PROD_W + 1;
   localparam int HALF_W       = ADJ_W - DATA_W;
   localparam int PP_W         = ADJ_W;
   localparam int TERM_W       = PP_W + DATA_W;
   localparam int DET_W        = TERM_W + 2;
   localparam int MAG_W        = DET_W - 1;
   localparam int AMAG_W       = PROD_W;
   localparam int Q_W          = 32;
   localparam int CMP_W        = MAG_W + Q_W;
   localparam int TOL_W        = 63;
   localparam int CSR_DW       = 64;
   localparam int CSR_AW       = 4;
   localparam int DIV_STAGES   = Q_W;
   localparam int FRAC_DEFAULT = 16;

   localparam logic [TOL_W-1:0]  TOL_RESET   = 63'd281474977;
   localparam logic              REG_TOL_IDX = 1'b0;
   localparam logic [DATA_W-1:0] SAT_POS     = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] SAT_NEG     = 32'h8000_0000;

   // operand indices of each cofactor: p*q - r*s
   localparam logic [3:0] COF_TBL [0:N_ELEM-1][0:3] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7},
      '{4'd2, 4'd7, 4'd1, 4'd8},
      '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd5, 4'd6, 4'd3, 4'd8},
      '{4'd0, 4'd8, 4'd2, 4'd6},
      '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd4, 4'd6},
      '{4'd1, 4'd6, 4'd0, 4'd7},
      '{4'd0, 4'd4, 4'd1, 4'd3}
   };

   typedef logic [N_ELEM-1:0][DATA_W-1:0] m3i_mat_type;

   typedef struct packed {
      logic [N_ELEM-1:0][ADJ_W-1:0] adj;
      logic [N_ROW-1:0][DATA_W-1:0] row;
   } m3i_adj_type;

   typedef struct packed {
      logic [MAG_W-1:0] rem;
      logic [Q_W-1:0]   sh;
      logic             neg;
      logic             ovf;
   } m3i_lane_type;

   typedef struct packed {
      m3i_lane_type [N_ELEM-1:0] lane;
      logic [MAG_W-1:0]          dvsr;
      logic                      singular;
   } m3i_div_type;

endpackage

>>> src/matrix3x3_inverse_top.sv
// 3x3 fixed-point matrix inverse: adjugate over determinant, fully pipelined
// a request passes the adjugate, determinant and divider stages, then the output register
// throughput: one request per cycle while the output is not stalled; 32 one-bit divider stages set the depth
// every stage has its own valid bit, so bubbles close up under an output stall
// reset: synchronous, clears all valid bits and loads the tolerance default
module matrix3x3_inverse_top #(
   parameter int FRAC_BITS = m3i_pkg::FRAC_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [m3i_pkg::DATA_W-1:0] req_a11,
   input  logic signed [m3i_pkg::DATA_W-1:0] req_a12,
   input  logic signed [m3i_pkg::DATA_W-1:0] req_a13,
   input  logic signed [m3i_pkg::DATA_W-1:0] req_a21,
   input  logic signed [m3i_pkg::DATA_W-1:0] req_a22,
   input  logic signed [m3i_pkg::DATA_W-1:0] req_a23,
   input  logic signed [m3i_pkg::DATA_W-1:0] req_a31,
   input  logic signed [m3i_pkg::DATA_W-1:0] req_a32,
   input  logic signed [m3i_pkg::DATA_W-1:0] req_a33,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [m3i_pkg::DATA_W-1:0] rsp_b11,
   output logic signed [m3i_pkg::DATA_W-1:0] rsp_b12,
   output logic signed [m3i_pkg::DATA_W-1:0] rsp_b13,
   output logic signed [m3i_pkg::DATA_W-1:0] rsp_b21,
   output logic signed [m3i_pkg::DATA_W-1:0] rsp_b22,
   output logic signed [m3i_pkg::DATA_W-1:0] rsp_b23,
   output logic signed [m3i_pkg::DATA_W-1:0] rsp_b31,
   output logic signed [m3i_pkg::DATA_W-1:0] rsp_b32,
   output logic signed [m3i_pkg::DATA_W-1:0] rsp_b33,
   output logic                          rsp_singular,
   // register port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [m3i_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [m3i_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [m3i_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import m3i_pkg::*;

   // tolerance register, one 64-bit slot at byte address 0
   logic [TOL_W-1:0] tol_ff, tol_in;
   logic             csr_wr;
   logic             csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_AW-1];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign tol_in     = (csr_wr && csr_idx == REG_TOL_IDX) ? csr_pwdata[TOL_W-1:0] : tol_ff;
   assign csr_prdata = (csr_idx == REG_TOL_IDX) ? {{(CSR_DW-TOL_W){1'b0}}, tol_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else begin
         tol_ff <= tol_in;
      end
   end

   // matrix packed row by row, element 0 is a11
   m3i_mat_type req_mat;
   assign req_mat = {req_a33, req_a32, req_a31, req_a23, req_a22, req_a21,
                     req_a13, req_a12, req_a11};

   // adjugate stages
   logic        adj_valid, adj_ready;
   m3i_adj_type adj_data;

   m3i_adj u_adj (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_mat    (req_mat),
      .out_valid (adj_valid),
      .out_ready (adj_ready),
      .out_adj   (adj_data)
   );

   // determinant and divider set-up
   logic        div_v [0:DIV_STAGES];
   logic        div_r [0:DIV_STAGES];
   m3i_div_type div_d [0:DIV_STAGES];

   m3i_det #(
      .FRAC_BITS (FRAC_BITS)
   ) u_det (
      .clock     (clock),
      .reset     (reset),
      .tolerance (tol_ff),
      .in_valid  (adj_valid),
      .in_ready  (adj_ready),
      .in_adj    (adj_data),
      .out_valid (div_v[0]),
      .out_ready (div_r[0]),
      .out_div   (div_d[0])
   );

   // one quotient bit per stage, most significant first
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      m3i_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_v[s]),
         .in_ready  (div_r[s]),
         .in_div    (div_d[s]),
         .out_valid (div_v[s+1]),
         .out_ready (div_r[s+1]),
         .out_div   (div_d[s+1])
      );
   end

   // sign, saturation and singular override into the output register
   logic                         rsp_valid_ff;
   logic [N_ELEM-1:0][DATA_W-1:0] rsp_b_in, rsp_b_ff;
   logic                         rsp_sing_ff;
   logic                         out_rdy;

   assign out_rdy                = !rsp_valid_ff || rsp_ready;
   assign div_r[DIV_STAGES]      = out_rdy;

   for (genvar k = 0; k < N_ELEM; k++) begin : g_sat
      always_comb begin
         if (div_d[DIV_STAGES].singular) begin
            rsp_b_in[k] = '0;
         end else if (div_d[DIV_STAGES].lane[k].neg) begin
            // negative side reaches one step further than positive
            if (div_d[DIV_STAGES].lane[k].ovf || div_d[DIV_STAGES].lane[k].sh > SAT_NEG) begin
               rsp_b_in[k] = SAT_NEG;
            end else begin
               rsp_b_in[k] = -div_d[DIV_STAGES].lane[k].sh;
            end
         end else begin
            if (div_d[DIV_STAGES].lane[k].ovf || div_d[DIV_STAGES].lane[k].sh[Q_W-1]) begin
               rsp_b_in[k] = SAT_POS;
            end else begin
               rsp_b_in[k] = div_d[DIV_STAGES].lane[k].sh;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_valid_ff <= div_v[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy) begin
         rsp_b_ff    <= rsp_b_in;
         rsp_sing_ff <= div_d[DIV_STAGES].singular;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_singular = rsp_sing_ff;
   assign rsp_b11      = rsp_b_ff[0];
   assign rsp_b12      = rsp_b_ff[1];
   assign rsp_b13      = rsp_b_ff[2];
   assign rsp_b21      = rsp_b_ff[3];
   assign rsp_b22      = rsp_b_ff[4];
   assign rsp_b23      = rsp_b_ff[5];
   assign rsp_b31      = rsp_b_ff[6];
   assign rsp_b32      = rsp_b_ff[7];
   assign rsp_b33      = rsp_b_ff[8];

endmodule

>>> src/m3i_adj.sv
// cofactor products and adjugate entries, two pipeline stages
module m3i_adj (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  m3i_pkg::m3i_mat_type in_mat,
   output logic                out_valid,
   input  logic                out_ready,
   output m3i_pkg::m3i_adj_type out_adj
);
   import m3i_pkg::*;

   logic [2*N_ELEM-1:0][PROD_W-1:0] prod_in, prod_ff;
   logic [N_ROW-1:0][DATA_W-1:0]    row_ff;
   logic                            v1_ff, v2_ff, rdy1, rdy2;
   m3i_adj_type                     adj_in, adj_ff;

   assign rdy2     = !v2_ff || out_ready;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   for (genvar k = 0; k < N_ELEM; k++) begin : g_prod
      assign prod_in[2*k]   = PROD_W'($signed(in_mat[COF_TBL[k][0]]) *
                                      $signed(in_mat[COF_TBL[k][1]]));
      assign prod_in[2*k+1] = PROD_W'($signed(in_mat[COF_TBL[k][2]]) *
                                      $signed(in_mat[COF_TBL[k][3]]));
      assign adj_in.adj[k]  = ADJ_W'($signed(prod_ff[2*k])) -
                              ADJ_W'($signed(prod_ff[2*k+1]));
   end
   assign adj_in.row = row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         prod_ff <= prod_in;
         row_ff  <= in_mat[N_ROW-1:0];
      end
      if (rdy2) adj_ff <= adj_in;
   end

   assign out_valid = v2_ff;
   assign out_adj   = adj_ff;

endmodule

>>> src/m3i_det.sv
// determinant, magnitudes, singular test and divider set-up, five stages
module m3i_det #(
   parameter int FRAC_BITS = m3i_pkg::FRAC_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [m3i_pkg::TOL_W-1:0]    tolerance,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  m3i_pkg::m3i_adj_type         in_adj,
   output logic                         out_valid,
   input  logic                         out_ready,
   output m3i_pkg::m3i_div_type         out_div
);
   import m3i_pkg::*;

   logic [4:0] v_ff;
   logic [4:0] rdy;

   // stage 3: split partial products of the first-row expansion
   logic [N_ROW-1:0][PP_W-1:0] plo_in, plo_ff, phi_in, phi_ff;
   logic [N_ELEM-1:0][ADJ_W-1:0] adj3_ff, adj4_ff, adj5_ff;
   // stage 4: expansion terms
   logic [N_ROW-1:0][TERM_W-1:0] term_in, term_ff;
   // stage 5: determinant
   logic [DET_W-1:0] det_in, det_ff;
   // stage 6: magnitudes and signs
   logic [DET_W-1:0]               det_neg;
   logic [MAG_W-1:0]               dmag_in, dmag_ff;
   logic [N_ELEM-1:0][ADJ_W-1:0]   adj_neg;
   logic [N_ELEM-1:0][AMAG_W-1:0]  amag_in, amag_ff;
   logic [N_ELEM-1:0]              neg_in, neg_ff;
   // stage 7: divider set-up
   logic [N_ELEM-1:0][CMP_W-1:0]   numer;
   logic [CMP_W-1:0]               dshift;
   m3i_div_type                    div_in, div_ff;

   assign rdy[4] = !v_ff[4] || out_ready;
   for (genvar s = 0; s < 4; s++) begin : g_rdy
      assign rdy[s] = !v_ff[s] || rdy[s+1];
   end
   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         for (int s = 1; s < 5; s++) begin
            if (rdy[s]) v_ff[s] <= v_ff[s-1];
         end
      end
   end

   for (genvar k = 0; k < N_ROW; k++) begin : g_row
      assign plo_in[k]  = PP_W'($signed(in_adj.row[k]) *
                                $signed({1'b0, in_adj.adj[3*k][DATA_W-1:0]}));
      assign phi_in[k]  = PP_W'($signed(in_adj.row[k]) *
                                $signed(in_adj.adj[3*k][ADJ_W-1:DATA_W]));
      assign term_in[k] = $signed({phi_ff[k], {DATA_W{1'b0}}}) +
                          TERM_W'($signed(plo_ff[k]));
   end

   assign det_in = DET_W'($signed(term_ff[0])) + DET_W'($signed(term_ff[1])) +
                   DET_W'($signed(term_ff[2]));

   assign det_neg = -det_ff;
   assign dmag_in = det_ff[DET_W-1] ? det_neg[MAG_W-1:0] : det_ff[MAG_W-1:0];

   for (genvar k = 0; k < N_ELEM; k++) begin : g_elem
      assign adj_neg[k] = -adj5_ff[k];
      assign amag_in[k] = adj5_ff[k][ADJ_W-1] ? adj_neg[k][AMAG_W-1:0]
                                              : adj5_ff[k][AMAG_W-1:0];
      assign neg_in[k]  = adj5_ff[k][ADJ_W-1] ^ det_ff[DET_W-1];
      // numerator is |adj| scaled up by two fraction widths
      assign numer[k]   = CMP_W'(amag_ff[k]) << (2 * FRAC_BITS);
      assign div_in.lane[k].rem = numer[k][CMP_W-1:Q_W];
      assign div_in.lane[k].sh  = numer[k][Q_W-1:0];
      assign div_in.lane[k].neg = neg_ff[k];
      // quotient of 2^32 or more saturates unless the matrix is flagged singular
      assign div_in.lane[k].ovf = (numer[k] >= dshift);
   end

   assign dshift          = {dmag_ff, {Q_W{1'b0}}};
   assign div_in.dvsr     = dmag_ff;
   assign div_in.singular = ({{(MAG_W-TOL_W){1'b0}}, tolerance} >= dmag_ff);

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
         adj3_ff <= in_adj.adj;
      end
      if (rdy[1]) begin
         term_ff <= term_in;
         adj4_ff <= adj3_ff;
      end
      if (rdy[2]) begin
         det_ff  <= det_in;
         adj5_ff <= adj4_ff;
      end
      if (rdy[3]) begin
         dmag_ff <= dmag_in;
         amag_ff <= amag_in;
         neg_ff  <= neg_in;
      end
      if (rdy[4]) div_ff <= div_in;
   end

   assign out_valid = v_ff[4];
   assign out_div   = div_ff;

endmodule

>>> src/m3i_div_step.sv
// one restoring division step across all nine lanes
module m3i_div_step (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  m3i_pkg::m3i_div_type in_div,
   output logic                 out_valid,
   input  logic                 out_ready,
   output m3i_pkg::m3i_div_type out_div
);
   import m3i_pkg::*;

   logic                          v_ff, rdy;
   logic [N_ELEM-1:0][MAG_W:0]    trial;
   logic [N_ELEM-1:0][MAG_W:0]    diff;
   logic [N_ELEM-1:0]             qbit;
   m3i_div_type                   div_in, div_ff;

   assign rdy      = !v_ff || out_ready;
   assign in_ready = rdy;

   for (genvar k = 0; k < N_ELEM; k++) begin : g_lane
      assign trial[k] = {in_div.lane[k].rem, in_div.lane[k].sh[Q_W-1]};
      assign diff[k]  = trial[k] - {1'b0, in_div.dvsr};
      assign qbit[k]  = (trial[k] >= {1'b0, in_div.dvsr});
      assign div_in.lane[k].rem = qbit[k] ? diff[k][MAG_W-1:0] : trial[k][MAG_W-1:0];
      // numerator bits leave at the top, quotient bits enter at the bottom
      assign div_in.lane[k].sh  = {in_div.lane[k].sh[Q_W-2:0], qbit[k]};
      assign div_in.lane[k].neg = in_div.lane[k].neg;
      assign div_in.lane[k].ovf = in_div.lane[k].ovf;
   end
   assign div_in.dvsr     = in_div.dvsr;
   assign div_in.singular = in_div.singular;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (rdy) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy) div_ff <= div_in;
   end

   assign out_valid = v_ff;
   assign out_div   = div_ff;

endmodule
